@@ rtl/rfpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfpc_pkg
// Shared constants, types and helpers for the rise/fall peak counter.
// ----------------------------------------------------------------------------
package rfpc_pkg;

    // Event counters (window, rise, fall)
    localparam int CNT_WIDTH = 17;
    typedef logic [CNT_WIDTH-1:0] cnt_t;

    // Configuration port
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;
    typedef logic [CFG_IDX_WIDTH-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_WIDTH-1:0] cfg_data_t;

    // Register indexes
    localparam cfg_idx_t CFG_MIN_RISE_STEP = 2'd0;
    localparam cfg_idx_t CFG_MIN_COUNT     = 2'd1;
    localparam cfg_idx_t CFG_MAX_WINDOW    = 2'd2;

    // Register widths and reset values
    localparam int STEP_WIDTH  = 16;
    localparam int COUNT_WIDTH = 8;
    localparam int WIN_WIDTH   = 16;
    typedef logic [STEP_WIDTH-1:0]  step_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [WIN_WIDTH-1:0]   win_t;

    localparam step_t  MIN_RISE_STEP_RST = 16'd0;
    localparam count_t MIN_COUNT_RST     = 8'd3;
    localparam win_t   MAX_WINDOW_RST    = 16'd100;

    // A step below this value counts as a fall
    localparam int FALL_STEP = -100;

    // Counter increment that sticks at all ones
    function automatic cnt_t sat_inc(input cnt_t c);
        cnt_t r;
        r = (&c) ? c : c + cnt_t'(1);
        return r;
    endfunction

endpackage

@@ rtl/rise_fall_peak_counter.sv @@
// ----------------------------------------------------------------------------
// rise_fall_peak_counter
// Valley-peak-valley detector over a stream of signed sensor samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample) carries one signed sample per
//   beat; the output channel (out_valid / out_stall / peak_found) returns one
//   flag per sample, in order. A beat moves when valid is high and stall low.
//   The sample is first held in an input register; the detector state and the
//   result register update together when that sample moves on.
//   Throughput: 1 sample per cycle while the receiver does not stall; the state
//   update (step, compare, counter increments) sets that rate.
//   Receiver stall: the result register holds; the input register keeps its
//   sample and in_stall goes high once it is occupied, so nothing is lost.
//   Configuration: cfg_we writes cfg_data to the register at cfg_index
//   (0 min_rise_step, 1 min_count, 2 max_window); write only while idle.
//   Reset: registers return to 0 / 3 / 100, all detector state and both
//   pipeline valids are cleared.
// ----------------------------------------------------------------------------
module rise_fall_peak_counter #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration
    input  logic                           cfg_we,
    input  rfpc_pkg::cfg_idx_t             cfg_index,
    input  rfpc_pkg::cfg_data_t            cfg_data,
    // sample channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           peak_found
);

    // Compare width: holds the step and the unsigned rise threshold
    localparam int DW = SAMPLE_WIDTH + 1;
    localparam int CW = ((DW > rfpc_pkg::STEP_WIDTH + 1) ? DW : rfpc_pkg::STEP_WIDTH + 1) + 1;
    localparam logic signed [CW-1:0] FALL_LIM = CW'(rfpc_pkg::FALL_STEP);

    // Configuration registers
    rfpc_pkg::step_t  min_rise_step_reg;
    rfpc_pkg::count_t min_count_reg;
    rfpc_pkg::win_t   max_window_reg;

    // Pipeline registers
    logic                           s1_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sample_reg;
    logic                           out_valid_reg;
    logic                           peak_found_reg;

    // Detector state
    logic signed [SAMPLE_WIDTH-1:0] previous_sample_reg, previous_sample_next;
    logic signed [SAMPLE_WIDTH-1:0] running_max_reg, running_max_next;
    rfpc_pkg::cnt_t                 window_count_reg, window_count_next;
    rfpc_pkg::cnt_t                 rise_count_reg, rise_count_next;
    rfpc_pkg::cnt_t                 fall_count_reg, fall_count_next;
    logic                           peak_next;

    // Datapath intermediates
    logic signed [DW-1:0]           step;
    logic signed [CW-1:0]           step_ext;
    logic signed [CW-1:0]           rise_lim;
    logic                           win_clear;
    logic signed [SAMPLE_WIDTH-1:0] rmax_mid;
    rfpc_pkg::cnt_t                 win_mid, rise_mid, fall_mid, fall_inc;
    logic                           rise_hit, fall_hit, fall_done, enough_rises;

    // Handshake
    logic s1_fire;
    logic out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign out_valid  = out_valid_reg;
    assign peak_found = peak_found_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rise_step_reg <= rfpc_pkg::MIN_RISE_STEP_RST;
            min_count_reg     <= rfpc_pkg::MIN_COUNT_RST;
            max_window_reg    <= rfpc_pkg::MAX_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfpc_pkg::CFG_MIN_RISE_STEP: min_rise_step_reg <= cfg_data;
                rfpc_pkg::CFG_MIN_COUNT:
                    min_count_reg <= cfg_data[rfpc_pkg::COUNT_WIDTH-1:0];
                rfpc_pkg::CFG_MAX_WINDOW:    max_window_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Step and threshold compares
    assign step     = DW'(s1_sample_reg) - DW'(previous_sample_reg);
    assign step_ext = CW'(step);
    assign rise_lim = $signed(CW'(min_rise_step_reg));

    // Window check runs first on the old count
    assign win_clear = window_count_reg > rfpc_pkg::cnt_t'(max_window_reg);
    assign rmax_mid  = win_clear ? '0 : running_max_reg;
    assign win_mid   = win_clear ? '0 : rfpc_pkg::sat_inc(window_count_reg);
    assign rise_mid  = win_clear ? '0 : rise_count_reg;
    assign fall_mid  = win_clear ? '0 : fall_count_reg;

    assign rise_hit     = (step_ext > rise_lim) && (s1_sample_reg > rmax_mid);
    assign fall_hit     = step_ext < FALL_LIM;
    assign fall_inc     = rfpc_pkg::sat_inc(fall_mid);
    assign fall_done    = fall_inc >= rfpc_pkg::cnt_t'(min_count_reg);
    assign enough_rises = rise_mid >= rfpc_pkg::cnt_t'(min_count_reg);

    // Next state of the detector
    always_comb
    begin
        previous_sample_next = s1_sample_reg;
        running_max_next     = rmax_mid;
        window_count_next    = win_mid;
        rise_count_next      = rise_mid;
        fall_count_next      = fall_mid;
        peak_next            = 1'b0;
        if (rise_hit)
        begin
            running_max_next = s1_sample_reg;
            rise_count_next  = rfpc_pkg::sat_inc(rise_mid);
            fall_count_next  = '0;
        end
        else if (fall_hit)
        begin
            if (fall_done)
            begin
                running_max_next  = '0;
                window_count_next = '0;
                rise_count_next   = '0;
                fall_count_next   = '0;
                peak_next         = enough_rises;
                // previous sample stays put on a detection
                if (enough_rises)
                    previous_sample_next = previous_sample_reg;
            end
            else
            begin
                fall_count_next = fall_inc;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            previous_sample_reg <= '0;
            running_max_reg     <= '0;
            window_count_reg    <= '0;
            rise_count_reg      <= '0;
            fall_count_reg      <= '0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
            begin
                previous_sample_reg <= previous_sample_next;
                running_max_reg     <= running_max_next;
                window_count_reg    <= window_count_next;
                rise_count_reg      <= rise_count_next;
                fall_count_reg      <= fall_count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_sample_reg <= sample;
        if (s1_fire)
            peak_found_reg <= peak_next;
    end

    // Assertions
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("result register not loaded after sample moved on");

    a_peak_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && peak_next |=> rise_count_reg == '0 && fall_count_reg == '0
            && window_count_reg == '0 && peak_found_reg)
        else $error("detection did not clear the event state");

    a_rise_sets_max: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && rise_hit |=> running_max_reg == $past(s1_sample_reg)
            && fall_count_reg == '0)
        else $error("rise did not record the new maximum");

endmodule

@@ sim/tb_rise_fall_peak_counter.sv @@
// ----------------------------------------------------------------------------
// tb_rise_fall_peak_counter
// Self-checking bench for the rise/fall peak counter. A local copy of the
// detector state predicts peak_found for every accepted sample; results are
// matched in order. Directed checks cover sample extremes, clean peaks,
// falls without enough rises, a zero count threshold, window expiry and
// register masking. Random phases then run valley-peak-valley shapes with
// noise under several register settings, with bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_rise_fall_peak_counter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SW             = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam rfpc_pkg::cfg_idx_t CFG_UNUSED_IDX = 2'd3;

    // DUT ports
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    rfpc_pkg::cfg_idx_t   cfg_index = rfpc_pkg::CFG_MIN_RISE_STEP;
    rfpc_pkg::cfg_data_t  cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic signed [SW-1:0] sample    = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 peak_found;

    // Predictor copy of registers and detector state
    rfpc_pkg::step_t      min_step  = rfpc_pkg::MIN_RISE_STEP_RST;
    rfpc_pkg::count_t     min_cnt   = rfpc_pkg::MIN_COUNT_RST;
    rfpc_pkg::win_t       max_win   = rfpc_pkg::MAX_WINDOW_RST;
    logic signed [SW-1:0] prev_smp  = '0;
    logic signed [SW-1:0] run_max   = '0;
    rfpc_pkg::cnt_t       win_cnt   = '0;
    rfpc_pkg::cnt_t       rise_cnt  = '0;
    rfpc_pkg::cnt_t       fall_cnt  = '0;

    // Expected flags, oldest first
    logic peak_expect_q[$];
    logic exp_peak;

    // Traffic shaping
    int gap_max    = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int hold_left  = 0;

    // Bookkeeping
    int err_cnt      = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int peaks_seen   = 0;
    int quiet_cycles = 0;

    rise_fall_peak_counter #(.SAMPLE_WIDTH(SW)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .peak_found (peak_found)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic rfpc_pkg::cnt_t bump(input rfpc_pkg::cnt_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic void clear_event();
        run_max  = '0;
        win_cnt  = '0;
        rise_cnt = '0;
        fall_cnt = '0;
    endfunction

    function automatic logic predict_peak(input logic signed [SW-1:0] s);
        int   d;
        logic hit;
        d = int'(s) - int'(prev_smp);
        // window test uses the count from before this sample
        if (win_cnt > rfpc_pkg::cnt_t'(max_win))
            clear_event();
        else
            win_cnt = bump(win_cnt);
        if (d > int'(min_step) && s > run_max) begin
            run_max  = s;
            rise_cnt = bump(rise_cnt);
            fall_cnt = '0;
        end
        else if (d < rfpc_pkg::FALL_STEP) begin
            fall_cnt = bump(fall_cnt);
            if (fall_cnt >= rfpc_pkg::cnt_t'(min_cnt)) begin
                hit = (rise_cnt >= rfpc_pkg::cnt_t'(min_cnt));
                clear_event();
                // previous sample is kept on a detection
                if (hit)
                    return 1'b1;
            end
        end
        prev_smp = s;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and result checker
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else begin
            case (stall_mode)
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (peak_expect_q.size() == 0) begin
                $error("peak_found: no beat expected, got %0b", peak_found);
                err_cnt++;
            end
            else begin
                exp_peak = peak_expect_q.pop_front();
                results_seen++;
                if (exp_peak)
                    peaks_seen++;
                if (peak_found !== exp_peak) begin
                    $error("peak_found: expected %0b, got %0b", exp_peak, peak_found);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: cycles with no beat on either channel
    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("rise_fall_peak_counter: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------
    task automatic send_sample(input logic signed [SW-1:0] v);
        int gap;
        // bursts of random length separated by random gaps
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        peak_expect_q.push_back(predict_peak(v));
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (peak_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input rfpc_pkg::cfg_idx_t idx, input rfpc_pkg::cfg_data_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            rfpc_pkg::CFG_MIN_RISE_STEP: min_step = rfpc_pkg::step_t'(val);
            rfpc_pkg::CFG_MIN_COUNT:     min_cnt  = rfpc_pkg::count_t'(val);
            rfpc_pkg::CFG_MAX_WINDOW:    max_win  = rfpc_pkg::win_t'(val);
            default: ;
        endcase
    endtask

    task automatic set_config(input int step, input int cnt, input int win);
        write_reg(rfpc_pkg::CFG_MIN_RISE_STEP, rfpc_pkg::cfg_data_t'(step));
        write_reg(rfpc_pkg::CFG_MIN_COUNT, rfpc_pkg::cfg_data_t'(cnt));
        write_reg(rfpc_pkg::CFG_MAX_WINDOW, rfpc_pkg::cfg_data_t'(win));
    endtask

    function automatic int clamp16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_sample_extremes();
        send_sample(-32768);
        send_sample(32767);
        send_sample(0);
        send_sample(-1);
        wait_idle();
    endtask

    // three rises then three falls under reset settings
    task automatic test_basic_peak();
        send_sample(100);
        send_sample(200);
        send_sample(300);
        send_sample(100);
        send_sample(-100);
        send_sample(-300);
        wait_idle();
    endtask

    // enough falls after a single rise: state clears, no flag
    task automatic test_falls_without_rises();
        send_sample(2000);
        send_sample(1500);
        send_sample(1000);
        send_sample(500);
        wait_idle();
    endtask

    // zero threshold: any fall completes a peak
    task automatic test_zero_min_count();
        set_config(0, 0, 100);
        send_sample(500);
        send_sample(300);
        wait_idle();
    endtask

    // zero window: state clears every other sample
    task automatic test_window_expiry();
        set_config(0, 1, 0);
        send_sample(100);
        send_sample(200);
        send_sample(50);
        send_sample(-200);
        wait_idle();
    endtask

    // upper data bits ignored, unused index has no effect
    task automatic test_register_masking();
        write_reg(rfpc_pkg::CFG_MIN_COUNT, 16'hFF02);
        write_reg(rfpc_pkg::CFG_MAX_WINDOW, 16'd65534);
        write_reg(CFG_UNUSED_IDX, 16'hFFFF);
        send_sample(-50);
        send_sample(400);
        send_sample(900);
        send_sample(200);
        send_sample(-600);
        wait_idle();
    endtask

    // valley-peak-valley shapes with random content, plus noise
    task automatic run_shapes(input int target);
        int cur;
        int nr;
        int nf;
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0) begin
                send_sample(SW'($urandom));
            end
            else begin
                if (min_step > 2000)
                    cur = -32768 + $urandom_range(0, 300);
                else
                    cur = $urandom_range(0, 600) - 300;
                send_sample(SW'(cur));
                nr = int'(min_cnt) + $urandom_range(0, 2) - 1;
                nr = (nr < 1) ? 1 : (nr > 12 ? 12 : nr);
                nf = int'(min_cnt) + $urandom_range(0, 2) - 1;
                nf = (nf < 1) ? 1 : (nf > 12 ? 12 : nf);
                repeat (nr) begin
                    cur = clamp16(cur + int'(min_step) + $urandom_range(0, 400));
                    send_sample(SW'(cur));
                end
                repeat (nf) begin
                    cur = clamp16(cur - $urandom_range(90, 3000));
                    send_sample(SW'(cur));
                end
            end
        end
    endtask

    task automatic test_random_phase(input int step, input int cnt, input int win,
                                     input int n, input int gaps, input int stalls);
        set_config(step, cnt, win);
        gap_max    = gaps;
        stall_mode = stalls;
        run_shapes(items_sent + n);
        wait_idle();
    endtask

    // long output hold-off while input keeps coming
    task automatic test_backpressure();
        set_config(0, 3, 100);
        gap_max    = 0;
        stall_mode = 0;
        hold_left  = 80;
        run_shapes(items_sent + 40);
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_sample_extremes();
        test_basic_peak();
        test_falls_without_rises();
        test_zero_min_count();
        test_window_expiry();
        test_register_masking();
        test_backpressure();

        test_random_phase(0, 3, 100, 70, 0, 0);
        test_random_phase(0, 3, 100, 60, 6, 1);
        test_random_phase(0, 0, 0, 50, 3, 2);
        test_random_phase(65535, 255, 65534, 40, 4, 1);
        test_random_phase(40000, 1, 20, 50, 2, 0);
        test_random_phase($urandom_range(0, 500), $urandom_range(1, 6),
                          $urandom_range(5, 60), 70, 5, 1);
        test_random_phase($urandom_range(0, 500), $urandom_range(1, 6),
                          $urandom_range(5, 60), 70, 0, 2);
        test_random_phase(1, 2, 65534, 50, 8, 0);

        wait_idle();
        if (peak_expect_q.size() != 0) begin
            $error("peak_found: %0d beats never arrived", peak_expect_q.size());
            err_cnt++;
        end

        $display("%0d samples driven, %0d flags compared, %0d peaks seen", items_sent,
                 results_seen, peaks_seen);
        $display("settings from zero to full thresholds, window expiry, long output hold-off");
        if (err_cnt == 0)
            $display("rise_fall_peak_counter: match");
        else
            $display("rise_fall_peak_counter: mismatch");
        $finish;
    end

endmodule
